@@ hdl/csc_pkg.sv @@
package csc_pkg;

    // pi = 2^31, half and quarter pi in the same binary-angle units
    localparam logic [31:0] K_PI         = 32'h8000_0000;
    localparam logic [31:0] K_HALF_PI    = 32'h4000_0000;
    localparam logic [31:0] K_QUARTER_PI = 32'h2000_0000;

    // start vector (1.0, 0.5) with 1.0 at bit 30
    localparam int unsigned K_VEC_W = 33;
    localparam logic signed [K_VEC_W-1:0] K_X0 = 33'sd1073741824;
    localparam logic signed [K_VEC_W-1:0] K_Y0 = 33'sd536870912;

    // pi/4 with 62 fraction bits
    localparam logic [63:0] K_PI4_Q62 = 64'h3243_F6A8_885A_308D;

    localparam int K_ATAN_MAX = 30;

    typedef struct packed {
        logic valid;
        logic swap;
        logic sin_neg;
        logic cos_neg;
    } t_ctl;

    // restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-k) with 62 fraction bits, power series
    function automatic logic [63:0] atan_q62(input int k);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        int          n;
        t   = 64'd1 << (62 - k);
        sum = t;
        n   = 1;
        for (int i = 0; i < 64; i++) begin
            if (t != 64'd0) begin
                t    = t >> (2 * k);
                term = udiv64(t, 64'(2 * n + 1));
                if (n[0])
                    sum = sum - term;
                else
                    sum = sum + term;
                n = n + 1;
            end
        end
        return sum;
    endfunction

    // atan(2^-k) in binary-angle units, truncated
    function automatic logic [31:0] atan_entry(input int k);
        logic [63:0] r;
        logic [63:0] q;
        r = atan_q62(k);
        q = '0;
        for (int j = 0; j < 29; j++) begin
            r = r << 1;
            q = q << 1;
            if (r >= K_PI4_Q62) begin
                r    = r - K_PI4_Q62;
                q[0] = 1'b1;
            end
        end
        return q[31:0];
    endfunction

    // inverse gain, 1.0 at bit 32
    function automatic logic [31:0] inv_gain(input int iters);
        logic [63:0] g;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] b;
        g = 64'd1 << 62;
        for (int k = 1; k <= K_ATAN_MAX; k++) begin
            if (k <= iters)
                g = g + (g >> (2 * k));
        end
        r = 64'd1 << 62;
        q = '0;
        for (int j = 0; j < 64; j++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r    = r - g;
                q[0] = 1'b1;
            end
        end
        num = q;
        res = '0;
        b   = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > num)
                b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (num >= res + b) begin
                    num = num - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res[31:0];
    endfunction

endpackage

@@ hdl/csc_fold.sv @@
module csc_fold (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [31:0]                   i_angle,
    output csc_pkg::t_ctl                        o_ctl,
    output logic signed [31:0]                   o_a
);
    import csc_pkg::*;

    logic [31:0] mag1;
    logic [31:0] mag2;
    t_ctl        n_ctl;
    logic [31:0] n_a;
    t_ctl        r_ctl;
    logic [31:0] r_a;

    always_comb begin
        mag1          = i_angle[31] ? (32'd0 - i_angle) : i_angle;
        n_ctl.valid   = i_valid;
        n_ctl.sin_neg = i_angle[31];
        // magnitude is unsigned so minus pi folds to zero
        n_ctl.cos_neg = (mag1 > K_HALF_PI);
        mag2          = n_ctl.cos_neg ? (K_PI - mag1) : mag1;
        n_ctl.swap    = (mag2 > K_QUARTER_PI);
        n_a           = n_ctl.swap ? (K_HALF_PI - mag2) : mag2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = $signed(r_a);

endmodule

@@ hdl/csc_cell.sv @@
module csc_cell #(
    parameter int K = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  csc_pkg::t_ctl                        i_ctl,
    input  logic signed [31:0]                   i_a,
    input  logic signed [csc_pkg::K_VEC_W-1:0]   i_x,
    input  logic signed [csc_pkg::K_VEC_W-1:0]   i_y,
    output csc_pkg::t_ctl                        o_ctl,
    output logic signed [31:0]                   o_a,
    output logic signed [csc_pkg::K_VEC_W-1:0]   o_x,
    output logic signed [csc_pkg::K_VEC_W-1:0]   o_y
);
    import csc_pkg::*;

    localparam logic signed [31:0] ATAN = $signed(atan_entry(K));

    logic signed [31:0]        n_a;
    logic signed [K_VEC_W-1:0] n_x;
    logic signed [K_VEC_W-1:0] n_y;
    logic signed [K_VEC_W-1:0] x_sh;
    logic signed [K_VEC_W-1:0] y_sh;
    t_ctl                      r_ctl;
    logic signed [31:0]        r_a;
    logic signed [K_VEC_W-1:0] r_x;
    logic signed [K_VEC_W-1:0] r_y;

    always_comb begin
        n_a  = i_a[31] ? (i_a + ATAN) : (i_a - ATAN);
        x_sh = i_x >>> (K + 1);
        y_sh = i_y >>> (K + 1);
        // zero residual counts as positive
        if (!n_a[31]) begin
            n_x = i_x - y_sh;
            n_y = i_y + x_sh;
        end else begin
            n_x = i_x + y_sh;
            n_y = i_y - x_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

@@ hdl/csc_scale.sv @@
module csc_scale #(
    parameter int ITERATIONS = 15
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en_mul,
    input  logic                                 i_en_out,
    input  csc_pkg::t_ctl                        i_ctl,
    input  logic signed [csc_pkg::K_VEC_W-1:0]   i_x,
    input  logic signed [csc_pkg::K_VEC_W-1:0]   i_y,
    output logic                                 o_mul_valid,
    output logic                                 o_valid,
    output logic signed [31:0]                   o_sine,
    output logic signed [31:0]                   o_cosine
);
    import csc_pkg::*;

    localparam logic [31:0] GAIN = inv_gain(ITERATIONS);
    localparam int PROD_W = 2 * K_VEC_W;

    logic signed [K_VEC_W-1:0] gain_s;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    t_ctl                      r_ctl;
    logic [31:0]               r_px;
    logic [31:0]               r_py;
    logic                      r_valid;
    logic [31:0]               r_sine;
    logic [31:0]               r_cosine;
    logic [31:0]               sel_s;
    logic [31:0]               sel_c;
    logic [31:0]               n_sine;
    logic [31:0]               n_cosine;

    assign gain_s = $signed({1'b0, GAIN});
    assign prod_x = i_x * gain_s;
    assign prod_y = i_y * gain_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en_mul) begin
            r_ctl <= i_ctl;
        end
    end

    // keep bits 63:32 of the product, so 1.0 lands at bit 30
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_px <= prod_x[63:32];
            r_py <= prod_y[63:32];
        end
    end

    always_comb begin
        sel_s    = r_ctl.swap ? r_px : r_py;
        sel_c    = r_ctl.swap ? r_py : r_px;
        n_sine   = r_ctl.sin_neg ? (32'd0 - sel_s) : sel_s;
        n_cosine = r_ctl.cos_neg ? (32'd0 - sel_c) : sel_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en_out) begin
            r_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_sine   <= n_sine;
            r_cosine <= n_cosine;
        end
    end

    assign o_mul_valid = r_ctl.valid;
    assign o_valid     = r_valid;
    assign o_sine      = $signed(r_sine);
    assign o_cosine    = $signed(r_cosine);

endmodule

@@ hdl/cordic_sine_cosine_top.sv @@
// channel   direction   signals                       beat carries
// angle     in          i_valid, o_ready, i_angle      one signed angle, pi = 2^31
// result    out         o_valid, i_ready, o_sine,      sine and cosine, 1.0 = 2^30
//                       o_cosine
//
// one beat per cycle sustained while i_ready is high; the pipeline registers are
// fold register, ITERATIONS-1 rotation cells, product register, output register
// each register stage loads when empty or when the stage after it moves, so
// bubbles close up and o_ready stays high while any stage is free
// synchronous active-low reset clears only the valid bits
module cordic_sine_cosine_top #(
    parameter int ITERATIONS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sine,
    output logic signed [31:0] o_cosine
);
    import csc_pkg::*;

    // stage index: 0 fold, 1..N-1 cells, N product, N+1 output
    localparam int N    = ITERATIONS;
    localparam int LAST = ITERATIONS + 1;

    t_ctl                      ctl [N];
    logic signed [31:0]        ang [N];
    logic signed [K_VEC_W-1:0] vx  [N];
    logic signed [K_VEC_W-1:0] vy  [N];

    logic [LAST:0] stage_valid;
    logic [LAST:0] stage_load;
    logic          mul_valid;

    // fold the angle into the first octant
    csc_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (stage_load[0]),
        .i_valid (i_valid),
        .i_angle (i_angle),
        .o_ctl   (ctl[0]),
        .o_a     (ang[0])
    );

    // start vector is the same for every beat
    assign vx[0] = K_X0;
    assign vy[0] = K_Y0;

    // one micro-rotation per cell, shift k+1 in cell k
    for (genvar k = 1; k < N; k++) begin : g_cell
        csc_cell #(
            .K (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (stage_load[k]),
            .i_ctl   (ctl[k-1]),
            .i_a     (ang[k-1]),
            .i_x     (vx[k-1]),
            .i_y     (vy[k-1]),
            .o_ctl   (ctl[k]),
            .o_a     (ang[k]),
            .o_x     (vx[k]),
            .o_y     (vy[k])
        );
    end

    // gain correction, then octant unfold and sign fixes
    csc_scale #(
        .ITERATIONS (ITERATIONS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en_mul    (stage_load[N]),
        .i_en_out    (stage_load[LAST]),
        .i_ctl       (ctl[N-1]),
        .i_x         (vx[N-1]),
        .i_y         (vy[N-1]),
        .o_mul_valid (mul_valid),
        .o_valid     (o_valid),
        .o_sine      (o_sine),
        .o_cosine    (o_cosine)
    );

    // per-stage load: empty, or the downstream stage is moving
    always_comb begin
        for (int i = 0; i < N; i++) begin
            stage_valid[i] = ctl[i].valid;
        end
        stage_valid[N]    = mul_valid;
        stage_valid[LAST] = o_valid;
        stage_load[LAST]  = !o_valid || i_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_load[i] = !stage_valid[i] || stage_load[i+1];
        end
    end

    assign o_ready = stage_load[0];

`ifndef SYNTHESIS
    // with the output stalled, a new beat is only taken into a free stage
    a_ready_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && !i_ready) |-> ($countones(stage_valid) < (LAST + 1)))
        else $error("input taken with every stage full");

    // an accepted beat lands in the fold register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> ctl[0].valid)
        else $error("accepted angle lost at fold stage");

    // folded angle is inside the first octant
    a_octant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl[0].valid |-> (!ang[0][31] && (ang[0] <= $signed({1'b0, K_QUARTER_PI[30:0]}))))
        else $error("folded angle outside first octant");
`endif

endmodule
